[hw/rtl/ffha_pkg.sv]
// Package for the first-fit heap allocator: sizes, status codes and block table types.
// No dependencies.
`timescale 1ns / 1ps

package ffha_pkg;

    localparam int HEAP_BYTES   = 524288;
    localparam int HEADER_BYTES = 24;
    localparam int ALIGN_BYTES  = 8;
    localparam int MAX_BLOCKS   = 64;
    localparam int MIN_SPLIT    = 8;

    localparam int OFS_W = 19;
    localparam int REQ_W = 32;
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    // Width that holds a rounded request plus header without wrapping.
    localparam int SUM_W = REQ_W + 2;

    // Status codes of a result.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_NULL = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // One entry of the block table: header offset, user size, free mark.
    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [OFS_W-1:0] size;
        logic             free;
    } t_blk;

    localparam int BLK_W = $bits(t_blk);

endpackage

[hw/rtl/ffha_if.sv]
// Valid/ready channel interfaces for the heap allocator requests and results.
// Depends on ffha_pkg.
`timescale 1ns / 1ps

interface ffha_req_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [ffha_pkg::REQ_W-1:0] request_size;
    logic [ffha_pkg::OFS_W-1:0] pointer_offset;

    modport source (output valid, mode, request_size, pointer_offset, input ready);
    modport sink (input valid, mode, request_size, pointer_offset, output ready);
endinterface

interface ffha_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [ffha_pkg::OFS_W-1:0] user_offset;
    logic [ffha_pkg::OFS_W-1:0] granted_bytes;

    modport source (output valid, status, user_offset, granted_bytes, input ready);
    modport sink (input valid, status, user_offset, granted_bytes, output ready);
endinterface

[hw/rtl/first_fit_heap_allocator.sv]
// The allocator serves one request at a time. An allocate walks the block table in address
// order, reading and then inspecting each entry, and a split then shifts every later entry
// up by one, reading and then writing each entry moved; a free walks to its block the same
// way and each merge shifts later entries down. A zero-size allocate or a null free goes
// straight to its error result with no table walk. Every step goes through the one table
// RAM.
// Ready is low while a request is in work; the result waits in an output register, and the
// next request is taken as soon as that result has left. No clearing pass is needed after
// reset.
// Depends on ffha_pkg, ffha_if and ffha_ram.
`timescale 1ns / 1ps

module first_fit_heap_allocator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ffha_req_if.sink       i_req,
    ffha_rsp_if.source     o_rsp
);

    localparam int OW = ffha_pkg::OFS_W;
    localparam int IW = ffha_pkg::IDX_W;
    localparam int CW = ffha_pkg::CNT_W;
    localparam int SW = ffha_pkg::SUM_W;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_RD     = 11'b00000000010, // issue read of entry r_idx
        S_CHK    = 11'b00000000100, // inspect entry r_idx
        S_SH_RD  = 11'b00000001000, // read entry for a shift
        S_SH_WR  = 11'b00000010000, // write shifted entry
        S_FIN_A  = 11'b00000100000, // write split tail, then granted entry
        S_NB_RD  = 11'b00001000000, // read a neighbor for merging
        S_NB_CHK = 11'b00010000000,
        S_MRG_WR = 11'b00100000000, // write merged entry
        S_ERR    = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_mode;
    logic [SW-1:0]          r_need;
    logic [OW-1:0]          r_ptr;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_idx;      // entry under work
    logic [CW-1:0]          r_sh;       // shift pointer
    logic                   r_sh_up;    // shift direction
    logic [1:0]             r_phase;    // free: 0 next merge, 1 prev merge
    ffha_pkg::t_blk         r_cur;      // entry found
    ffha_pkg::t_blk         r_tail;     // split remainder
    logic                   r_v0;       // entry 0 written since reset
    logic                   r_o_valid;
    logic [1:0]             r_o_status;
    logic [OW-1:0]          r_o_ofs;
    logic [OW-1:0]          r_o_size;

    logic                   ram_we;
    logic [IW-1:0]          ram_wa, ram_ra;
    ffha_pkg::t_blk         ram_wd, ram_rd, rd;
    logic [IW-1:0]          r_ra;

    ffha_ram #(.WIDTH(ffha_pkg::BLK_W), .DEPTH(ffha_pkg::MAX_BLOCKS)) u_tab (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_wa),
        .i_wdata(ram_wd),
        .i_raddr(ram_ra),
        .o_rdata(ram_rd)
    );

    // Entry 0 reads as the whole free heap until first written.
    always_comb begin
        rd = ram_rd;
        if (!r_v0 && r_ra == '0) begin
            rd.start = '0;
            rd.size  = OW'(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES);
            rd.free  = 1'b1;
        end
    end

    // Rounded request and split arithmetic from the entry read.
    logic [SW-1:0] need_in;
    logic [SW-1:0] total, split_lim;
    logic          fit, split_ok;
    assign need_in = (SW'(i_req.request_size) + SW'(ffha_pkg::ALIGN_BYTES - 1))
                     & ~SW'(ffha_pkg::ALIGN_BYTES - 1);
    assign total = (r_need + SW'(ffha_pkg::HEADER_BYTES + ffha_pkg::ALIGN_BYTES - 1))
                   & ~SW'(ffha_pkg::ALIGN_BYTES - 1);
    assign split_lim = r_need + SW'(ffha_pkg::HEADER_BYTES + ffha_pkg::MIN_SPLIT);
    assign fit = rd.free && SW'(rd.size) >= r_need;
    assign split_ok = SW'(rd.size) > split_lim && SW'(rd.size) >= total
                      && r_count < CW'(ffha_pkg::MAX_BLOCKS);
    logic ptr_hit;
    assign ptr_hit = (OW+1)'(rd.start) + (OW+1)'(ffha_pkg::HEADER_BYTES) == (OW+1)'(r_ptr);

    assign i_req.ready     = (r_state == S_IDLE) && !r_o_valid;
    assign o_rsp.valid     = r_o_valid;
    assign o_rsp.status    = r_o_status;
    assign o_rsp.user_offset   = r_o_ofs;
    assign o_rsp.granted_bytes = r_o_size;

    // RAM port steering.
    always_comb begin
        ram_we = 1'b0;
        ram_wa = r_idx[IW-1:0];
        ram_wd = r_cur;
        ram_ra = r_idx[IW-1:0];
        case (r_state)
            S_SH_RD: ram_ra = r_sh_up ? IW'(r_sh - CW'(1)) : IW'(r_sh + CW'(1));
            S_SH_WR: begin
                ram_we = 1'b1;
                ram_wa = r_sh[IW-1:0];
                ram_wd = rd;
            end
            S_FIN_A: begin
                ram_we = 1'b1;
                ram_wa = r_phase[0] ? IW'(r_idx + CW'(1)) : r_idx[IW-1:0];
                ram_wd = r_phase[0] ? r_tail : r_cur;
            end
            S_NB_RD: ram_ra = r_phase == 2'd0 ? IW'(r_idx + CW'(1)) : IW'(r_idx - CW'(1));
            S_MRG_WR: begin
                ram_we = 1'b1;
                ram_wd = r_cur;
            end
            default: ;
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= CW'(1);
            r_v0      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_ra <= ram_ra;
            if (ram_we && ram_wa == '0) r_v0 <= 1'b1;
            if (o_rsp.valid && o_rsp.ready) r_o_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_req.valid && i_req.ready) begin
                    r_mode  <= i_req.mode;
                    r_need  <= need_in;
                    r_ptr   <= i_req.pointer_offset;
                    r_idx   <= '0;
                    r_phase <= 2'd0;
                    if (i_req.mode == ffha_pkg::MODE_ALLOC && i_req.request_size == '0) begin
                        r_o_status <= ffha_pkg::ST_FAIL;
                        r_state <= S_ERR;
                    end else if (i_req.mode == ffha_pkg::MODE_FREE
                                 && i_req.pointer_offset == '0) begin
                        r_o_status <= ffha_pkg::ST_NULL;
                        r_state <= S_ERR;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (r_mode == ffha_pkg::MODE_ALLOC) begin
                        if (fit) begin
                            r_o_status <= ffha_pkg::ST_OK;
                            r_o_ofs  <= OW'(rd.start + OW'(ffha_pkg::HEADER_BYTES));
                            if (split_ok) begin
                                r_cur <= '{start: rd.start,
                                           size: OW'(total - SW'(ffha_pkg::HEADER_BYTES)),
                                           free: 1'b0};
                                r_o_size     <= OW'(total - SW'(ffha_pkg::HEADER_BYTES));
                                r_tail.start <= OW'(SW'(rd.start) + total);
                                r_tail.size  <= OW'(SW'(rd.size) - total);
                                r_tail.free  <= 1'b1;
                                r_phase <= 2'd1;
                                r_sh    <= r_count;
                                r_sh_up <= 1'b1;
                                r_count <= r_count + CW'(1);
                                r_state <= (r_count == r_idx + CW'(1)) ? S_FIN_A : S_SH_RD;
                            end else begin
                                r_cur <= '{start: rd.start, size: rd.size, free: 1'b0};
                                r_o_size <= rd.size;
                                r_phase  <= 2'd0;
                                r_state  <= S_FIN_A;
                            end
                        end else if (r_idx + CW'(1) >= r_count) begin
                            r_o_status <= ffha_pkg::ST_FAIL;
                            r_state <= S_ERR;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        if (ptr_hit) begin
                            if (rd.free) begin
                                r_o_status <= ffha_pkg::ST_BAD;
                                r_state <= S_ERR;
                            end else begin
                                r_cur <= '{start: rd.start, size: rd.size, free: 1'b1};
                                r_o_status <= ffha_pkg::ST_OK;
                                r_o_ofs  <= '0;
                                r_o_size <= '0;
                                r_phase <= 2'd0;
                                r_state <= (r_idx + CW'(1) < r_count) ? S_NB_RD : S_MRG_WR;
                            end
                        end else if (r_idx + CW'(1) >= r_count) begin
                            r_o_status <= ffha_pkg::ST_BAD;
                            r_state <= S_ERR;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                // Move one entry by one place; up for a split, down for a merge.
                S_SH_RD: r_state <= S_SH_WR;
                S_SH_WR: begin
                    if (r_sh_up) begin
                        r_sh <= r_sh - CW'(1);
                        r_state <= (r_sh - CW'(1) == r_idx + CW'(1)) ? S_FIN_A : S_SH_RD;
                    end else begin
                        r_sh <= r_sh + CW'(1);
                        if (r_sh + CW'(2) >= r_count) begin
                            r_count <= r_count - CW'(1);
                            r_state <= S_MRG_WR;
                        end else begin
                            r_state <= S_SH_RD;
                        end
                    end
                end
                S_FIN_A: begin
                    if (r_phase[0]) r_phase <= 2'd0;
                    else begin
                        r_o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_NB_RD: r_state <= S_NB_CHK;
                S_NB_CHK: begin
                    if (rd.free) begin
                        if (r_phase == 2'd0) begin
                            r_cur.size <= r_cur.size + OW'(ffha_pkg::HEADER_BYTES) + rd.size;
                            r_sh <= r_idx + CW'(1);
                        end else begin
                            r_cur <= '{start: rd.start,
                                       size: rd.size + OW'(ffha_pkg::HEADER_BYTES)
                                             + r_cur.size,
                                       free: r_cur.free};
                            r_sh <= r_idx;
                            r_idx <= r_idx - CW'(1);
                        end
                        r_sh_up <= 1'b0;
                        if ((r_phase == 2'd0 ? r_idx + CW'(2) : r_idx + CW'(1)) >= r_count) begin
                            r_count <= r_count - CW'(1);
                            r_state <= S_MRG_WR;
                        end else begin
                            r_state <= S_SH_RD;
                        end
                    end else begin
                        r_state <= S_MRG_WR;
                    end
                end
                // Write the merged block, then try the left neighbor once.
                S_MRG_WR: begin
                    if (r_phase == 2'd0 && r_idx != '0) begin
                        r_phase <= 2'd1;
                        r_state <= S_NB_RD;
                    end else begin
                        r_o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_ERR: begin
                    r_o_ofs  <= '0;
                    r_o_size <= '0;
                    r_o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CW'(1) && r_count <= CW'(ffha_pkg::MAX_BLOCKS))
        else $error("block count out of range");
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !i_req.ready)
        else $error("ready while busy");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status != ffha_pkg::ST_OK |-> o_rsp.user_offset == '0)
        else $error("failed result carries an offset");
    a_rsp_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !o_rsp.valid)
        else $error("result before request finished");
`endif

endmodule

[hw/rtl/ffha_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[sim/first_fit_heap_allocator_tb.sv]
// Self-checking testbench for the first-fit heap allocator: directed table plus random traffic.
// Depends on ffha_pkg, ffha_if and the allocator RTL.
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;

    localparam int REQ_W        = ffha_pkg::REQ_W;
    localparam int OFS_W        = ffha_pkg::OFS_W;
    localparam int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS;
    localparam int HEAP_BYTES   = ffha_pkg::HEAP_BYTES;
    localparam int HEADER_BYTES = ffha_pkg::HEADER_BYTES;
    localparam int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES;
    localparam int MIN_SPLIT    = ffha_pkg::MIN_SPLIT;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 830;
    localparam int HOLD_CYCLES    = 400;

    // One row of the directed table; chk marks rows whose result is typed in.
    typedef struct {
        logic             mode;
        logic [REQ_W-1:0] size;
        logic [OFS_W-1:0] ptr;
        bit               chk;
        logic [1:0]       st;
        logic [OFS_W-1:0] ofs;
        logic [OFS_W-1:0] bytes;
    } t_row;

    typedef struct packed {
        logic [1:0]       st;
        logic [OFS_W-1:0] ofs;
        logic [OFS_W-1:0] bytes;
    } t_grant;

    logic i_clk;
    logic i_rst_n;

    ffha_req_if req_ch ();
    ffha_rsp_if rsp_ch ();

    first_fit_heap_allocator u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    // Shadow heap table kept by the predictor.
    int unsigned heap_start [MAX_BLOCKS];
    int unsigned heap_size [MAX_BLOCKS];
    bit          heap_free [MAX_BLOCKS];
    int unsigned heap_count;

    t_grant      pending_grants[$];
    logic [OFS_W-1:0] live_ptrs[$];
    int          errors;
    int          n_sent;
    int          n_got;
    int          n_split_full;
    int          idle_cycles;
    bit          hold_off;
    bit          stim_done;

    always #5 i_clk = ~i_clk;

    function automatic void heap_reset();
        heap_start[0] = 0;
        heap_size[0]  = HEAP_BYTES - HEADER_BYTES;
        heap_free[0]  = 1'b1;
        heap_count    = 1;
    endfunction

    function automatic void heap_remove(int unsigned idx);
        for (int unsigned i = idx; i + 1 < heap_count; i++) begin
            heap_start[i] = heap_start[i+1];
            heap_size[i]  = heap_size[i+1];
            heap_free[i]  = heap_free[i+1];
        end
        heap_count--;
    endfunction

    // Computes the result of one request and updates the shadow table.
    function automatic t_grant heap_apply(logic mode, logic [REQ_W-1:0] size,
                                          logic [OFS_W-1:0] ptr);
        t_grant g;
        longint unsigned need;
        longint unsigned total;
        longint unsigned sz;
        int unsigned i;
        g = '{st: ffha_pkg::ST_FAIL, ofs: '0, bytes: '0};
        if (mode == ffha_pkg::MODE_ALLOC) begin
            if (size == 0) return g;
            need = ((longint'(size) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
            for (i = 0; i < heap_count; i++) begin
                sz = heap_size[i];
                if (heap_free[i] && sz >= need) begin
                    total = ((need + HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES)
                            * ALIGN_BYTES;
                    if (sz > need + HEADER_BYTES + MIN_SPLIT && sz >= total) begin
                        if (heap_count < MAX_BLOCKS) begin
                            for (int unsigned j = heap_count; j > i + 1; j--) begin
                                heap_start[j] = heap_start[j-1];
                                heap_size[j]  = heap_size[j-1];
                                heap_free[j]  = heap_free[j-1];
                            end
                            heap_start[i+1] = heap_start[i] + int'(total);
                            heap_size[i+1]  = int'(sz - total);
                            heap_free[i+1]  = 1'b1;
                            heap_count++;
                            heap_size[i] = int'(total - HEADER_BYTES);
                        end else begin
                            n_split_full++;
                        end
                    end
                    heap_free[i] = 1'b0;
                    g.st    = ffha_pkg::ST_OK;
                    g.ofs   = OFS_W'(heap_start[i] + HEADER_BYTES);
                    g.bytes = OFS_W'(heap_size[i]);
                    return g;
                end
            end
            return g;
        end
        if (ptr == 0) begin
            g.st = ffha_pkg::ST_NULL;
            return g;
        end
        for (i = 0; i < heap_count; i++)
            if (heap_start[i] + HEADER_BYTES == ptr) break;
        if (i >= heap_count || heap_free[i]) begin
            g.st = ffha_pkg::ST_BAD;
            return g;
        end
        heap_free[i] = 1'b1;
        if (i + 1 < heap_count && heap_free[i+1]) begin
            heap_size[i] += HEADER_BYTES + heap_size[i+1];
            heap_remove(i + 1);
        end
        if (i > 0 && heap_free[i-1]) begin
            heap_size[i-1] += HEADER_BYTES + heap_size[i];
            heap_remove(i);
        end
        g.st = ffha_pkg::ST_OK;
        return g;
    endfunction

    // Drives one request after a random gap, predicting its result at acceptance.
    // Valid stays high after the request until the next call or an idle stretch.
    task automatic send_request(logic mode, logic [REQ_W-1:0] size, logic [OFS_W-1:0] ptr,
                                bit chk, t_grant typed, int gap);
        t_grant g;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.mode           <= mode;
        req_ch.request_size   <= size;
        req_ch.pointer_offset <= ptr;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        g = heap_apply(mode, size, ptr);
        if (chk && g !== typed) begin
            $display("%0t: table row disagrees: expected %p, predicted %p", $time, typed, g);
            errors++;
        end
        if (mode == ffha_pkg::MODE_ALLOC && g.st == ffha_pkg::ST_OK) live_ptrs.push_back(g.ofs);
        pending_grants.push_back(g);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Drops valid and idles the sender for a number of cycles.
    task automatic send_idle(int n);
        req_ch.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Result checker: compares each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_grant exp_g;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            n_got++;
            if (pending_grants.size() == 0) begin
                $display("%0t: unexpected result st=%0d ofs=%0d bytes=%0d", $time,
                         rsp_ch.status, rsp_ch.user_offset, rsp_ch.granted_bytes);
                errors++;
            end else begin
                exp_g = pending_grants.pop_front();
                if (rsp_ch.status !== exp_g.st || rsp_ch.user_offset !== exp_g.ofs ||
                    rsp_ch.granted_bytes !== exp_g.bytes) begin
                    $display("%0t: mismatch expected st=%0d ofs=%0d bytes=%0d, got st=%0d ofs=%0d bytes=%0d",
                             $time, exp_g.st, exp_g.ofs, exp_g.bytes, rsp_ch.status,
                             rsp_ch.user_offset, rsp_ch.granted_bytes);
                    errors++;
                end
            end
        end
    end

    // Receiver stall pattern; on request it holds off for a counted stretch of cycles.
    initial begin
        int phase;
        rsp_ch.ready <= 1'b0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off = 1'b0;
            end
            if (phase < 300) rsp_ch.ready <= 1'b1;
            else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            phase = (phase + 1) % 1000;
        end
    end

    // Watchdog on cycles with nothing accepted.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_grant typed;
        int burst;
        int pick;
        logic [OFS_W-1:0] p;
        logic [REQ_W-1:0] sz;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = ffha_pkg::MODE_ALLOC;
        req_ch.request_size = '0;
        req_ch.pointer_offset = '0;
        errors = 0; n_sent = 0; n_got = 0; n_split_full = 0; idle_cycles = 0;
        hold_off = 1'b0; stim_done = 1'b0;
        typed = '0;
        heap_reset();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: extremes, null and bad frees, split and whole grants, merges.
        rows.push_back('{ffha_pkg::MODE_FREE,  '0, '0, 1, ffha_pkg::ST_NULL, '0, '0});
        rows.push_back('{ffha_pkg::MODE_FREE,  '0, 19'd24, 1, ffha_pkg::ST_BAD, '0, '0});
        rows.push_back('{ffha_pkg::MODE_ALLOC, '0, '0, 1, ffha_pkg::ST_FAIL, '0, '0});
        rows.push_back('{ffha_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 19'h7FFFF, 1,
                         ffha_pkg::ST_FAIL, '0, '0});
        rows.push_back('{ffha_pkg::MODE_ALLOC, 32'd1, '0, 1, ffha_pkg::ST_OK, 19'd24, 19'd8});
        rows.push_back('{ffha_pkg::MODE_ALLOC, 32'd17, '0, 1, ffha_pkg::ST_OK, 19'd56, 19'd24});
        rows.push_back('{ffha_pkg::MODE_FREE,  32'hFFFF_FFFF, 19'd24, 1,
                         ffha_pkg::ST_OK, '0, '0});
        rows.push_back('{ffha_pkg::MODE_FREE,  '0, 19'd24, 1, ffha_pkg::ST_BAD, '0, '0});
        rows.push_back('{ffha_pkg::MODE_FREE,  '0, 19'h7FFFF, 1, ffha_pkg::ST_BAD, '0, '0});
        rows.push_back('{ffha_pkg::MODE_ALLOC, 32'd16, '0, 0, ffha_pkg::ST_OK, '0, '0});
        rows.push_back('{ffha_pkg::MODE_FREE,  '0, 19'd56, 0, ffha_pkg::ST_OK, '0, '0});
        rows.push_back('{ffha_pkg::MODE_ALLOC, 32'd524264, '0, 0, ffha_pkg::ST_OK, '0, '0});
        rows.push_back('{ffha_pkg::MODE_ALLOC, 32'd524200, '0, 0, ffha_pkg::ST_OK, '0, '0});
        rows.push_back('{ffha_pkg::MODE_ALLOC, 32'd8, '0, 0, ffha_pkg::ST_OK, '0, '0});
        for (int i = 0; i < rows.size(); i++) begin
            typed = '{rows[i].st, rows[i].ofs, rows[i].bytes};
            send_request(rows[i].mode, rows[i].size, rows[i].ptr, rows[i].chk, typed,
                         $urandom_range(0, 3));
        end
        // Drain: free whatever is live so random traffic starts from an empty heap.
        while (live_ptrs.size() != 0) begin
            p = live_ptrs.pop_front();
            send_request(ffha_pkg::MODE_FREE, $urandom, p, 0, typed, 0);
        end

        // Random part: mostly allocs and frees of live pointers, with some noise.
        for (int n = 0; n < RANDOM_ITEMS; ) begin
            burst = $urandom_range(1, 20);
            send_idle($urandom_range(0, 12));
            for (int b = 0; b < burst && n < RANDOM_ITEMS; b++, n++) begin
                if (n == 200) hold_off = 1'b1;
                if (n == 400) begin
                    req_ch.valid <= 1'b0;
                    while (pending_grants.size() != 0) @(negedge i_clk);
                end
                pick = $urandom_range(0, 99);
                if (pick < 50 || live_ptrs.size() == 0) begin
                    case ($urandom_range(0, 9))
                        0: sz = $urandom;
                        1: sz = $urandom_range(0, 3);
                        2: sz = $urandom_range(4000, 40000);
                        default: sz = $urandom_range(1, 300);
                    endcase
                    send_request(ffha_pkg::MODE_ALLOC, sz, OFS_W'($urandom), 0, typed, 0);
                end else if (pick < 90) begin
                    pick = $urandom_range(0, live_ptrs.size() - 1);
                    p = live_ptrs[pick];
                    live_ptrs.delete(pick);
                    send_request(ffha_pkg::MODE_FREE, $urandom, p, 0, typed, 0);
                end else begin
                    // Null or random pointer.
                    p = ($urandom_range(0, 2) == 0) ? '0 : OFS_W'($urandom);
                    send_request(ffha_pkg::MODE_FREE, $urandom, p, 0, typed, 0);
                end
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_grants.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        $display("Covered %0d requests and %0d results, %0d grants made whole on a full table.",
                 n_sent, n_got, n_split_full);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
